@@ hdl/sklt_pkg.sv @@
// ----------------------------------------------------------------------------
// sklt_pkg
// shared types and default constants for the k-th largest tracker
// ----------------------------------------------------------------------------
package sklt_pkg;

    // width of the rank configuration register
    localparam int RANK_CFG_W      = 7;

    // defaults for the top level parameters
    localparam int DEF_MAX_RANK    = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    // cells per first-level group of the result reduction
    localparam int RED_GROUP       = 8;

    // control bits one cell hands to its right neighbor
    typedef struct packed {
        logic keep;   // entry is held and inside the current rank
        logic ge;     // held entry is not smaller than the incoming sample
    } cell_link_t;

    // what one cell offers to the result reduction
    typedef struct packed {
        logic tail;   // last held entry of the chain
        logic full;   // this cell is the rank-th entry and it is held
    } cell_flag_t;

endpackage

@@ hdl/sklt_cell.sv @@
// ----------------------------------------------------------------------------
// sklt_cell
// one slot of the sorted insertion chain: empties beyond the rank, else keeps,
// takes the sample, or takes its left neighbor's entry
// ----------------------------------------------------------------------------
module sklt_cell
    import sklt_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int RANK_W      = 7,
    parameter int INDEX       = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          shift_en,
    input  logic [RANK_W-1:0]             rank_eff,
    input  logic signed [VALUE_WIDTH-1:0] new_value,
    input  logic signed [VALUE_WIDTH-1:0] left_value,
    input  cell_link_t                    left_link,
    input  logic                          right_valid,
    output logic signed [VALUE_WIDTH-1:0] value_q,
    output cell_link_t                    link,
    output logic                          valid_q,
    output logic [VALUE_WIDTH-1:0]        res_value,
    output cell_flag_t                    res_flag
);

    logic signed [VALUE_WIDTH-1:0] value_reg, value_next;
    logic                          valid_reg, valid_next;
    logic                          in_rank;

    assign in_rank   = RANK_W'(INDEX) < rank_eff;
    assign link.keep = valid_reg & in_rank;
    assign link.ge   = link.keep & (value_reg >= new_value);

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (shift_en) begin
            if (!in_rank) begin
                // trimmed off by a smaller rank
                valid_next = 1'b0;
            end else if (link.ge) begin
                valid_next = 1'b1;
            end else if (left_link.ge) begin
                // insertion point
                value_next = new_value;
                valid_next = 1'b1;
            end else begin
                value_next = left_value;
                valid_next = left_link.keep;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_q       = value_reg;
    assign valid_q       = valid_reg;
    assign res_flag.tail = valid_reg & ~right_valid;
    assign res_flag.full = valid_reg & (rank_eff == RANK_W'(INDEX + 1));
    assign res_value     = res_flag.tail ? value_reg : '0;

endmodule

@@ hdl/streaming_kth_largest_tracker_core.sv @@
// ----------------------------------------------------------------------------
// streaming_kth_largest_tracker_core
// keeps the largest rank_k samples in a sorted chain of cells and reports
// the smallest kept one for every sample
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+-----------
//  sample   | s_valid s_ready s_sample_value          | in
//  result   | m_valid m_ready m_kth_value m_store_full | out
//  config   | cfg_wr_en cfg_wr_data (rank_k)          | in
//
//  a sample beat is taken in idle; its result passes the shift, reduce and
//  load steps of the sequencer around the chain and is loaded into the
//  output register in the load step; no new beat is taken before idle
//  reset empties the chain at once (per-cell valid flops), rank_k back to 1
//  a stalled result only holds the load step; the chain and output
//  register stay apart, so the next beat is taken while a result waits
//
module streaming_kth_largest_tracker_core
    import sklt_pkg::*;
#(
    parameter int MAX_RANK    = DEF_MAX_RANK,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_sample_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VALUE_WIDTH-1:0] m_kth_value,
    output logic                          m_store_full,
    input  logic                          cfg_wr_en,
    input  logic [RANK_CFG_W-1:0]         cfg_wr_data
);

    localparam int RANK_W     = $clog2(MAX_RANK + 1);
    localparam int CMP_W      = (RANK_W > RANK_CFG_W) ? RANK_W : RANK_CFG_W;
    localparam int NUM_GROUPS = (MAX_RANK + RED_GROUP - 1) / RED_GROUP;

    // sequencer, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SHIFT  = 4'b0010,
        ST_REDUCE = 4'b0100,
        ST_LOAD   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [RANK_CFG_W-1:0] rank_k_reg;
    logic [CMP_W-1:0]      rank_ext;
    logic [RANK_W-1:0]     rank_eff;

    // latched sample
    logic signed [VALUE_WIDTH-1:0] sample_reg;

    // chain wiring
    logic signed [VALUE_WIDTH-1:0] cell_value [MAX_RANK];
    cell_link_t                    cell_link  [MAX_RANK];
    logic                          cell_valid [MAX_RANK];
    logic [VALUE_WIDTH-1:0]        cell_res   [MAX_RANK];
    cell_flag_t                    cell_flag  [MAX_RANK];

    // reduction tree
    logic [VALUE_WIDTH-1:0] group_value_reg [NUM_GROUPS];
    logic                   group_full_reg  [NUM_GROUPS];
    logic [VALUE_WIDTH-1:0] group_value_next [NUM_GROUPS];
    logic                   group_full_next  [NUM_GROUPS];
    logic [VALUE_WIDTH-1:0] final_value;
    logic                   final_full;

    // output register
    logic                          m_valid_reg;
    logic signed [VALUE_WIDTH-1:0] m_kth_value_reg;
    logic                          m_store_full_reg;
    logic                          out_free;

    // rank zero acts as one, rank above the chain length saturates
    assign rank_ext = CMP_W'(rank_k_reg);
    always_comb begin
        if (rank_ext == '0) begin
            rank_eff = RANK_W'(1);
        end else if (rank_ext > CMP_W'(MAX_RANK)) begin
            rank_eff = RANK_W'(MAX_RANK);
        end else begin
            rank_eff = RANK_W'(rank_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_k_reg <= RANK_CFG_W'(1);
        end else if (cfg_wr_en) begin
            rank_k_reg <= cfg_wr_data;
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = ~m_valid_reg | m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SHIFT;
            end
            ST_SHIFT:  state_next = ST_REDUCE;
            ST_REDUCE: state_next = ST_LOAD;
            ST_LOAD: begin
                // wait here until the output slot frees up
                if (out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_sample_value;
        end
    end

    // the chain: every cell compares with the sample at once and either
    // keeps, takes the sample, takes its left neighbor's entry, or empties beyond the rank
    for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
        logic signed [VALUE_WIDTH-1:0] left_value;
        cell_link_t                    left_link;
        logic                          right_valid;

        if (i == 0) begin : g_head
            // head of the chain: the sample always fits here if nowhere left
            assign left_value     = sample_reg;
            assign left_link.keep = 1'b0;
            assign left_link.ge   = 1'b1;
        end else begin : g_body
            assign left_value = cell_value[i-1];
            assign left_link  = cell_link[i-1];
        end

        if (i == MAX_RANK - 1) begin : g_tail
            assign right_valid = 1'b0;
        end else begin : g_mid
            assign right_valid = cell_valid[i+1];
        end

        sklt_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .RANK_W      (RANK_W),
            .INDEX       (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .shift_en    (state_reg == ST_SHIFT),
            .rank_eff    (rank_eff),
            .new_value   (sample_reg),
            .left_value  (left_value),
            .left_link   (left_link),
            .right_valid (right_valid),
            .value_q     (cell_value[i]),
            .link        (cell_link[i]),
            .valid_q     (cell_valid[i]),
            .res_value   (cell_res[i]),
            .res_flag    (cell_flag[i])
        );
    end

    // first reduction level: or together the gated tail value and full flag per group
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            group_value_next[g] = '0;
            group_full_next[g]  = 1'b0;
            for (int j = 0; j < RED_GROUP; j++) begin
                if (g * RED_GROUP + j < MAX_RANK) begin
                    group_value_next[g] = group_value_next[g] | cell_res[g * RED_GROUP + j];
                    group_full_next[g]  = group_full_next[g]  | cell_flag[g * RED_GROUP + j].full;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_REDUCE) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                group_value_reg[g] <= group_value_next[g];
                group_full_reg[g]  <= group_full_next[g];
            end
        end
    end

    // second level
    always_comb begin
        final_value = '0;
        final_full  = 1'b0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            final_value = final_value | group_value_reg[g];
            final_full  = final_full  | group_full_reg[g];
        end
    end

    // output register, parts the chain from the result side
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_LOAD && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD && out_free) begin
            m_kth_value_reg  <= final_value;
            m_store_full_reg <= final_full;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kth_value  = m_kth_value_reg;
    assign m_store_full = m_store_full_reg;

endmodule

@@ hdl/sklt_checker.sv @@
// ----------------------------------------------------------------------------
// sklt_checker
// port-level checks for the k-th largest tracker, bound to the top level
// ----------------------------------------------------------------------------
module sklt_checker
    import sklt_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic signed [VALUE_WIDTH-1:0] s_sample_value,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [VALUE_WIDTH-1:0] m_kth_value,
    input logic                          m_store_full
);

    // a waiting sample beat holds
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_sample_value))
        else $error("sample beat changed while waiting");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kth_value) && $stable(m_store_full))
        else $error("result beat changed while stalled");

    // one sample beat at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sample beat taken while chain busy");

    // a result is loaded only as the chain goes idle
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result loaded while chain busy");

    // no result right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind streaming_kth_largest_tracker_core sklt_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_sklt_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_sample_value (s_sample_value),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_kth_value    (m_kth_value),
    .m_store_full   (m_store_full)
);
